[rtl/srt_pkg.sv]
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants of the segment range table unit.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int RANGES_DEF   = 16;

  localparam int OP_W     = 2;
  localparam int CH_W     = 2;
  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_e;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic tinit;
    logic rd;
    logic ev;
    logic tend;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic quick;
    logic is_find;
    logic more;
    logic stop;
    logic type_ok;
    logic covered;
    logic second;
  } sts_t;

endpackage

[rtl/srt_ctrl.sv]
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer that steps the datapath through one operation at a time.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  srt_pkg::sts_t sts_i,
  output srt_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_TINIT, S_LOOP, S_RD, S_EV, S_TEND, S_FIN, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        if (sts_i.quick) state_d = S_DONE;
        else if (sts_i.is_find) state_d = S_TINIT;
        else state_d = S_LOOP;
      end
      S_TINIT: begin
        cmd_o.tinit = 1'b1;
        state_d     = S_TEND;
        if (sts_i.type_ok) state_d = S_LOOP;
      end
      S_LOOP: begin
        if (sts_i.more && !sts_i.stop) state_d = S_RD;
        else if (sts_i.is_find) state_d = S_TEND;
        else state_d = S_FIN;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EV;
      end
      S_EV: begin
        cmd_o.ev = 1'b1;
        state_d  = S_LOOP;
      end
      S_TEND: begin
        cmd_o.tend = 1'b1;
        if (sts_i.covered || sts_i.second) state_d = S_DONE;
        else state_d = S_TINIT;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);

endmodule

[rtl/srt_dpath.sv]
// ----------------------------------------------------------------------------
// srt_dpath
// Range memory, list bookkeeping, scan registers and result registers.
// ----------------------------------------------------------------------------
module srt_dpath #(
  parameter int CHANNELS        = srt_pkg::CHANNELS_DEF,
  parameter int RANGES_PER_LIST = srt_pkg::RANGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [srt_pkg::OP_W-1:0]      operation_i,
  input  logic [srt_pkg::CH_W-1:0]      channel_i,
  input  logic                          mem_type_i,
  input  logic [srt_pkg::ADDR_W-1:0]    range_start_i,
  input  logic [srt_pkg::ADDR_W-1:0]    range_end_i,
  input  srt_pkg::cmd_t                 cmd_i,
  output srt_pkg::sts_t                 sts_o,
  output logic                          hit_o,
  output logic                          hit_type_o,
  output logic [srt_pkg::STATUS_W-1:0]  status_o
);

  localparam int NLISTS = 2 * CHANNELS;
  localparam int LW     = $clog2(NLISTS);
  localparam int IW     = (RANGES_PER_LIST > 1) ? $clog2(RANGES_PER_LIST) : 1;
  localparam int CW     = $clog2(RANGES_PER_LIST + 1);
  localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = NLISTS * (2 ** IW);
  localparam int AW     = LW + IW;
  localparam int DW     = 2 * srt_pkg::ADDR_W;

  logic [CW-1:0] count_q   [NLISTS];
  logic          present_q [NLISTS];
  logic          first_q   [CHANNELS];
  logic [DW-1:0] mem_q     [DEPTH];
  logic [DW-1:0] rd_q;

  logic [srt_pkg::OP_W-1:0]     op_q;
  logic [srt_pkg::CH_W-1:0]     ch_q;
  logic                         ty_q, cur_t_q, got_q, stop_q, found_q, second_q;
  logic [srt_pkg::ADDR_W-1:0]   s_q, e_q, reach_q, rp1_q;
  logic [CW-1:0]                idx_q;
  logic                         hit_q, hit_type_q;
  logic [srt_pkg::STATUS_W-1:0] status_q;

  logic                       ch_ok, full, quick, is_add, is_rem, is_find;
  logic [CHW-1:0]             ch_idx;
  logic [LW-1:0]              list, list_ty, list_t0, list_t1;
  logic [CW-1:0]              n;
  logic [srt_pkg::ADDR_W-1:0] ent_s, ent_e;
  logic [CW-1:0]              idx_m1;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [DW-1:0]              wr_data;
  logic                       type_ok, covered;

  assign is_add  = (op_q == srt_pkg::OP_ADD);
  assign is_rem  = (op_q == srt_pkg::OP_REMOVE);
  assign is_find = (op_q == srt_pkg::OP_FIND);
  assign ch_ok   = (int'(ch_q) < CHANNELS);
  assign ch_idx  = CHW'(ch_q);
  assign list    = LW'({ch_q, cur_t_q});
  assign list_ty = LW'({ch_q, ty_q});
  assign list_t0 = LW'({ch_q, 1'b0});
  assign list_t1 = LW'({ch_q, 1'b1});
  assign n       = count_q[list];
  assign full    = (int'(count_q[list_ty]) >= RANGES_PER_LIST);
  assign quick   = !ch_ok || (is_add && full) || !(is_add || is_rem || is_find);
  assign ent_s   = rd_q[srt_pkg::ADDR_W-1:0];
  assign ent_e   = rd_q[DW-1:srt_pkg::ADDR_W];
  assign idx_m1  = idx_q - CW'(1);
  assign type_ok = present_q[list] && (s_q <= e_q);
  assign covered = type_ok && got_q && (reach_q >= e_q);

  assign sts_o.quick   = quick;
  assign sts_o.is_find = is_find;
  assign sts_o.more    = is_add ? (idx_q != '0) : (idx_q < n);
  assign sts_o.stop    = stop_q;
  assign sts_o.type_ok = type_ok;
  assign sts_o.covered = covered;
  assign sts_o.second  = second_q;

  assign rd_addr = is_add ? {list, IW'(idx_m1)} : {list, IW'(idx_q)};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {list, IW'(idx_q)};
    wr_data = rd_q;
    if (cmd_i.ev && is_add && (ent_s > s_q)) begin
      wr_en = 1'b1;
    end else if (cmd_i.ev && is_rem && found_q) begin
      wr_en   = 1'b1;
      wr_addr = {list, IW'(idx_m1)};
    end else if (cmd_i.fin && is_add) begin
      wr_en   = 1'b1;
      wr_data = {e_q, s_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd) rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NLISTS; i++) begin
        count_q[i]   <= '0;
        present_q[i] <= 1'b0;
      end
      for (int i = 0; i < CHANNELS; i++) first_q[i] <= 1'b0;
    end else begin
      if (cmd_i.start && is_add && ch_ok) begin
        if (!present_q[list_t0] && !present_q[list_t1]) first_q[ch_idx] <= ty_q;
        present_q[list_ty] <= 1'b1;
      end
      if (cmd_i.fin && is_add) count_q[list] <= n + CW'(1);
      if (cmd_i.fin && is_rem && found_q) count_q[list] <= n - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      ch_q <= channel_i;
      ty_q <= mem_type_i;
      s_q  <= range_start_i;
      e_q  <= range_end_i;
    end
    if (cmd_i.start) begin
      cur_t_q    <= is_find ? first_q[ch_idx] : ty_q;
      idx_q      <= is_add ? count_q[list_ty] : '0;
      found_q    <= 1'b0;
      stop_q     <= 1'b0;
      second_q   <= 1'b0;
      hit_q      <= 1'b0;
      hit_type_q <= 1'b0;
      if (is_add && quick) status_q <= srt_pkg::ST_FULL;
      else if (is_rem) status_q <= srt_pkg::ST_NOMATCH;
      else status_q <= srt_pkg::ST_DONE;
    end
    if (cmd_i.tinit) begin
      idx_q   <= '0;
      reach_q <= s_q;
      rp1_q   <= s_q + 64'd1;
      got_q   <= 1'b0;
      stop_q  <= 1'b0;
    end
    if (cmd_i.ev) begin
      case (op_q)
        srt_pkg::OP_ADD: begin
          if (ent_s > s_q) idx_q <= idx_m1;
          else stop_q <= 1'b1;
        end
        srt_pkg::OP_REMOVE: begin
          idx_q <= idx_q + CW'(1);
          if (!found_q && ent_s == s_q && ent_e == e_q) found_q <= 1'b1;
        end
        default: begin
          idx_q <= idx_q + CW'(1);
          if (ent_s <= s_q) begin
            if (ent_e > s_q) begin
              got_q <= 1'b1;
              if (ent_e > reach_q) begin
                reach_q <= ent_e;
                rp1_q   <= ent_e + 64'd1;
              end
            end
          end else if (!got_q || ent_s > rp1_q) begin
            stop_q <= 1'b1;
          end else if (ent_e > reach_q) begin
            reach_q <= ent_e;
            rp1_q   <= ent_e + 64'd1;
          end
        end
      endcase
    end
    if (cmd_i.tend) begin
      if (covered) begin
        hit_q      <= 1'b1;
        hit_type_q <= cur_t_q;
      end else begin
        second_q <= 1'b1;
        cur_t_q  <= ~cur_t_q;
      end
    end
    if (cmd_i.fin && is_rem && found_q) status_q <= srt_pkg::ST_DONE;
  end

  assign hit_o      = hit_q;
  assign hit_type_o = hit_type_q;
  assign status_o   = status_q;

endmodule

[rtl/segment_range_table_unit.sv]
// ----------------------------------------------------------------------------
// segment_range_table_unit
// Sorted address range lists per channel and memory type with add, remove
// and range coverage lookup.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         operation, channel, mem_type, range_start, range_end
// m_axis    out        hit, hit_type, status
//
// One operation is in flight at a time. Each list entry visited passes through
// a check, a memory read and an evaluate step on the single-port range
// memory. A find may scan the lists of both memory types of its channel. The
// result is held on m_axis until its transfer completes, and s_axis is ready
// again in the cycle after that. Reset empties all lists at once.
// ----------------------------------------------------------------------------
module segment_range_table_unit #(
  parameter int CHANNELS        = srt_pkg::CHANNELS_DEF,
  parameter int RANGES_PER_LIST = srt_pkg::RANGES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // operation[1:0], channel[3:2], mem_type[4], range_start[68:5],
  // range_end[132:69], zero fill[135:133]
  input  logic [135:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // hit[0], hit_type[1], status[3:2], zero fill[7:4]
  output logic [7:0]   m_axis_tdata_o
);

  srt_pkg::cmd_t                cmd;
  srt_pkg::sts_t                sts;
  logic                         hit, hit_type;
  logic [srt_pkg::STATUS_W-1:0] status;

  srt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srt_dpath #(
    .CHANNELS        (CHANNELS),
    .RANGES_PER_LIST (RANGES_PER_LIST)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (s_axis_tdata_i[1:0]),
    .channel_i     (s_axis_tdata_i[3:2]),
    .mem_type_i    (s_axis_tdata_i[4]),
    .range_start_i (s_axis_tdata_i[68:5]),
    .range_end_i   (s_axis_tdata_i[132:69]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .hit_o         (hit),
    .hit_type_o    (hit_type),
    .status_o      (status)
  );

  assign m_axis_tdata_o = {4'b0000, status, hit_type, hit};

endmodule

[rtl/srt_checker.sv]
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks of the segment range table unit.
// ----------------------------------------------------------------------------
module srt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("Input is ready while a result is pending.");

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o && !m_axis_tvalid_o)
    else $error("An accepted transfer did not start an operation.");

  a_result_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:4] == 4'd0) && (m_axis_tdata_o[3:2] != 2'd3)
                        && !(m_axis_tdata_o[0] && m_axis_tdata_o[3:2] != 2'd0)
                        && !(!m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("Result fields are inconsistent.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("A stalled result changed.");

endmodule

bind segment_range_table_unit srt_checker u_srt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[tb/srt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srt_scoreboard
// Watches both streams of the range table, keeps its own copy of the range
// lists, predicts the answer to each operation and compares every result.
// ----------------------------------------------------------------------------
module srt_scoreboard #(
  parameter int CHANNELS        = srt_pkg::CHANNELS_DEF,
  parameter int RANGES_PER_LIST = srt_pkg::RANGES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [135:0] s_axis_tdata_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [7:0]   m_axis_tdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int LISTS = CHANNELS * 2;

  typedef struct packed {
    logic [1:0] status;
    logic       hit_type;
    logic       hit;
  } answer_t;

  logic [srt_pkg::ADDR_W-1:0] lo_mem [LISTS][RANGES_PER_LIST];
  logic [srt_pkg::ADDR_W-1:0] hi_mem [LISTS][RANGES_PER_LIST];
  int                         fill [LISTS];
  bit                         seen [LISTS];
  bit                         lead_type [CHANNELS];
  answer_t                    answers_q [$];
  int                         fails;

  assign fail_count_o = fails;
  assign pending_o    = answers_q.size();

  function automatic int upper_index(int l, logic [srt_pkg::ADDR_W-1:0] key);
    int i;
    i = 0;
    while (i < fill[l] && lo_mem[l][i] <= key) i++;
    return i;
  endfunction

  function automatic bit union_covers(int l, logic [srt_pkg::ADDR_W-1:0] s,
                                      logic [srt_pkg::ADDR_W-1:0] e);
    int                         split;
    logic [srt_pkg::ADDR_W-1:0] reach;
    bit                         got;
    if (s > e) return 0;
    reach = s;
    got   = 0;
    split = upper_index(l, s);
    for (int i = split; i > 0; i--) begin
      if (hi_mem[l][i-1] > s) begin
        if (hi_mem[l][i-1] > reach) reach = hi_mem[l][i-1];
        got = 1;
        if (reach >= e) return 1;
      end
    end
    if (!got) return 0;
    for (int i = split; i < fill[l]; i++) begin
      if (lo_mem[l][i] > reach + 64'd1) break;
      if (hi_mem[l][i] > reach) begin
        reach = hi_mem[l][i];
        if (reach >= e) return 1;
      end
    end
    return reach >= e;
  endfunction

  function automatic answer_t apply_op(logic [135:0] d);
    answer_t                    a;
    logic [1:0]                 op;
    int                         ch, ty, l, pos, t;
    logic [srt_pkg::ADDR_W-1:0] s, e;
    op = d[1:0];
    ch = int'(d[3:2]);
    ty = int'(d[4]);
    s  = d[68:5];
    e  = d[132:69];
    a  = '0;
    if (op == srt_pkg::OP_ADD) begin
      if (ch >= CHANNELS) begin
        a.status = srt_pkg::ST_FULL;
      end else begin
        l = ch * 2 + ty;
        if (!seen[ch*2] && !seen[ch*2+1]) lead_type[ch] = 1'(ty);
        seen[l] = 1;
        if (fill[l] >= RANGES_PER_LIST) begin
          a.status = srt_pkg::ST_FULL;
        end else begin
          pos = upper_index(l, s);
          for (int i = fill[l]; i > pos; i--) begin
            lo_mem[l][i] = lo_mem[l][i-1];
            hi_mem[l][i] = hi_mem[l][i-1];
          end
          lo_mem[l][pos] = s;
          hi_mem[l][pos] = e;
          fill[l]++;
        end
      end
    end else if (op == srt_pkg::OP_REMOVE) begin
      a.status = srt_pkg::ST_NOMATCH;
      if (ch < CHANNELS) begin
        l = ch * 2 + ty;
        for (int i = 0; i < fill[l]; i++) begin
          if (lo_mem[l][i] == s && hi_mem[l][i] == e) begin
            for (int j = i; j + 1 < fill[l]; j++) begin
              lo_mem[l][j] = lo_mem[l][j+1];
              hi_mem[l][j] = hi_mem[l][j+1];
            end
            fill[l]--;
            a.status = srt_pkg::ST_DONE;
            break;
          end
        end
      end
    end else if (op == srt_pkg::OP_FIND) begin
      if (ch < CHANNELS) begin
        for (int k = 0; k < 2; k++) begin
          t = (k == 0) ? int'(lead_type[ch]) : 1 - int'(lead_type[ch]);
          l = ch * 2 + t;
          if (seen[l] && union_covers(l, s, e)) begin
            a.hit      = 1'b1;
            a.hit_type = 1'(t);
            break;
          end
        end
      end
    end
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want, got;
    int      errs;
    errs = 0;
    if (!rst_ni) begin
      fails <= 0;
      answers_q.delete();
      for (int l = 0; l < LISTS; l++) begin
        fill[l] = 0;
        seen[l] = 0;
      end
      for (int c = 0; c < CHANNELS; c++) lead_type[c] = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        answers_q.insert(answers_q.size(), apply_op(s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[3:0];
        if (answers_q.size() == 0) begin
          $error("Result transfer with no operation outstanding: %h", m_axis_tdata_i);
          errs++;
        end else begin
          want = answers_q.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            errs++;
          end
          if (got.hit_type !== want.hit_type) begin
            $error("hit_type: expected %0d, actual %0d", want.hit_type, got.hit_type);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errs++;
          end
        end
      end
      if (errs != 0) fails <= fails + errs;
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, remove, find and invalid operations into the segment range table with
// random bursts and result stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ITEMS = 1000;
  localparam int LIMIT = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [135:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [7:0]   m_axis_tdata_o;
  int           fail_count, pending, idle_cycles;

  logic [63:0]  used_lo [$];
  logic [63:0]  used_hi [$];
  logic [3:0]   used_key [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segment_range_table_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  srt_scoreboard checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls in runs whose density changes from time to time.
  int stall_pct = 30;
  int stall_run = 0;
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_pct <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 90);
      stall_run <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_addr();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return rand64();
      default: return 64'(($urandom_range(0, 7) << 8) + $urandom_range(0, 300));
    endcase
  endfunction

  task automatic send(srt_pkg::op_e op, int ch, int ty, logic [63:0] s, logic [63:0] e);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b0, e, s, 1'(ty), 2'(ch), op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (op == srt_pkg::OP_ADD) begin
      used_lo.insert(used_lo.size(), s);
      used_hi.insert(used_hi.size(), e);
      used_key.insert(used_key.size(), {2'(ch), 1'(ty), 1'b0});
      if (used_lo.size() > 64) begin
        void'(used_lo.pop_front());
        void'(used_hi.pop_front());
        void'(used_key.pop_front());
      end
    end
  endtask

  task automatic gap();
    s_axis_tvalid_i <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  task automatic random_item();
    int          k, ch, ty, sel;
    logic [63:0] s, e;
    k  = $urandom_range(0, 99);
    ch = $urandom_range(0, 3);
    ty = $urandom_range(0, 1);
    s  = pick_addr();
    e  = ($urandom_range(0, 4) == 0) ? pick_addr() : s + $urandom_range(0, 600);
    if (e < s && $urandom_range(0, 3) != 0) e = '1;
    if (k < 40) begin
      send(srt_pkg::OP_ADD, ch, ty, s, e);
    end else if (k < 60) begin
      if (used_lo.size() > 0 && $urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, used_lo.size() - 1);
        send(srt_pkg::OP_REMOVE, used_key[sel][3:2], used_key[sel][1], used_lo[sel],
             used_hi[sel]);
      end else begin
        send(srt_pkg::OP_REMOVE, ch, ty, s, e);
      end
    end else if (k < 97) begin
      if (used_lo.size() > 0 && $urandom_range(0, 1) != 0) begin
        sel = $urandom_range(0, used_lo.size() - 1);
        s = used_lo[sel] + $urandom_range(0, 40);
        e = s + $urandom_range(0, 700);
        send(srt_pkg::OP_FIND, used_key[sel][3:2], ty, s, e);
      end else begin
        send(srt_pkg::OP_FIND, ch, ty, s, e);
      end
    end else begin
      send(srt_pkg::op_e'(2'd3), ch, ty, s, e);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(srt_pkg::OP_FIND, 0, 0, 64'd0, 64'd10);
    send(srt_pkg::OP_REMOVE, 1, 1, 64'd5, 64'd6);
    send(srt_pkg::OP_ADD, 0, 1, 64'd100, 64'd200);
    send(srt_pkg::OP_ADD, 0, 0, 64'd150, 64'd400);
    send(srt_pkg::OP_ADD, 0, 1, 64'd201, 64'd300);
    send(srt_pkg::OP_FIND, 0, 0, 64'd120, 64'd300);
    send(srt_pkg::OP_FIND, 0, 0, 64'd160, 64'd400);
    send(srt_pkg::OP_FIND, 0, 0, 64'd300, 64'd100);
    send(srt_pkg::OP_FIND, 0, 0, 64'd50, 64'd120);
    send(srt_pkg::OP_ADD, 3, 0, 64'd0, '1);
    send(srt_pkg::OP_FIND, 3, 1, 64'd0, '1);
    send(srt_pkg::OP_FIND, 3, 1, '1, '1);
    send(srt_pkg::OP_REMOVE, 0, 1, 64'd100, 64'd200);
    send(srt_pkg::OP_REMOVE, 0, 1, 64'd100, 64'd200);
    send(srt_pkg::OP_FIND, 0, 0, 64'd210, 64'd300);
    for (int i = 0; i < 17; i++) send(srt_pkg::OP_ADD, 2, 1, 64'd7, 64'(i));
    send(srt_pkg::OP_FIND, 2, 0, 64'd7, 64'd8);
    send(srt_pkg::op_e'(2'd3), 1, 1, '1, '1);
    for (int i = 0; i < 16; i++) send(srt_pkg::OP_REMOVE, 2, 1, 64'd7, 64'(i));

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    for (int n = 0; n < ITEMS; ) begin
      for (int b = $urandom_range(1, 20); b > 0; b--) begin
        random_item();
        n++;
      end
      if (n > ITEMS / 2 && n < ITEMS / 2 + 21) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 2) != 0) gap();
    end
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
